[hw/rtl/fixed_partition_fit_allocator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the partition fit allocator
// Simulation builds get the checks; synthesis builds get empty bodies.
// The checks sample on clk and are held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FPFA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fpfa assertion failed");
`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpfa assertion failed");
`else
`define FPFA_ASSERT(label, prop)
`define FPFA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/fpfa_pkg.sv]
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared codes and control structs of the partition fit allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpfa_pkg;

    // input item opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    // placement policies (code three behaves as first fit)
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    // configuration register indexes
    localparam logic REG_FIT_MODE    = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    typedef struct packed {
        logic init;
        logic step;
        logic keep_min;
        logic keep_max;
    } fit_ctrl_t;

    typedef struct packed {
        logic found;
        logic stop;
    } fit_status_t;

endpackage

[hw/rtl/fpfa_ram.sv]
// ----------------------------------------------------------------------------
// fpfa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fpfa_fit_unit.sv]
// ----------------------------------------------------------------------------
// fpfa_fit_unit
// Shared compare unit: checks one table entry per step and tracks the pick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpfa_fit_unit #(
    parameter int AW        = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpfa_pkg::fit_ctrl_t    ctrl,
    input  logic [AW-1:0]          entry_index,
    input  logic [SIZE_BITS-1:0]   entry_size,
    input  logic                   entry_used,
    input  logic [SIZE_BITS-1:0]   req_size,
    output fpfa_pkg::fit_status_t  status,
    output logic [AW-1:0]          pick,
    output logic [SIZE_BITS-1:0]   best
);

    logic                 found_reg, found_next;
    logic                 stop_reg, stop_next;
    logic [AW-1:0]        pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic                 fits;

    assign fits = !entry_used && (entry_size >= req_size);

    always_comb
    begin
        found_next = found_reg;
        stop_next  = stop_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (ctrl.init)
        begin
            found_next = 1'b0;
            stop_next  = 1'b0;
        end
        else if (ctrl.step && !stop_reg && fits)
        begin
            if (!found_reg)
            begin
                found_next = 1'b1;
                pick_next  = entry_index;
                best_next  = entry_size;
                // first fit ends the search on the first hit
                stop_next  = !(ctrl.keep_min || ctrl.keep_max);
            end
            else if (ctrl.keep_min && (entry_size < best_reg))
            begin
                pick_next = entry_index;
                best_next = entry_size;
            end
            else if (ctrl.keep_max && (entry_size > best_reg))
            begin
                pick_next = entry_index;
                best_next = entry_size;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            stop_reg  <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        best_reg <= best_next;
    end

    assign status.found = found_reg;
    assign status.stop  = stop_reg;
    assign pick         = pick_reg;
    assign best         = best_reg;

endmodule

[hw/rtl/fixed_partition_fit_allocator_unit.sv]
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_unit
// Load and clear items are done while idle. A request scans min(block_count,
// table depth) entries, fewer in first fit on an early hit, then writes its
// result register. The search rate is set by the size RAM read port.
// Reset clears control state and all used marks; sizes stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fixed_partition_fit_allocator_unit_assert.svh"

module fixed_partition_fit_allocator_unit #(
    parameter int MAX_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input item channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [3:0]  entry_index,
    input  logic [15:0] size_value,
    // result item channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        granted,
    output logic [3:0]  chosen_index,
    output logic [15:0] chosen_size,
    output logic [15:0] fragmentation
);

    // table address width, and a counter width that holds the depth itself
    localparam int AW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CW = $clog2(MAX_PARTITIONS + 1);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam logic [LW-1:0] MAX_LW = LW'(MAX_PARTITIONS);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           fit_mode_reg;
    logic [4:0]           block_count_reg;
    logic [LW-1:0]        scan_idx_reg, scan_idx_next;
    logic [LW-1:0]        limit_reg, limit_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [SIZE_BITS-1:0] req_size_reg, req_size_next;
    logic [MAX_PARTITIONS-1:0] used_reg, used_next;

    logic        out_valid_reg, out_valid_next;
    logic        granted_reg, granted_next;
    logic [3:0]  chosen_index_reg, chosen_index_next;
    logic [15:0] chosen_size_reg, chosen_size_next;
    logic [15:0] fragmentation_reg, fragmentation_next;

    logic                  cfg_write;
    logic                  in_accept;
    logic                  out_free;
    logic                  finish_go;
    logic                  done_scan;
    logic [LW-1:0]         count_lw;
    logic                  load_ok;
    logic                  ram_we;
    logic                  ram_re;
    logic [SIZE_BITS-1:0]  ram_rdata;
    logic [SIZE_BITS-1:0]  diff;
    fpfa_pkg::fit_ctrl_t   fit_ctrl;
    fpfa_pkg::fit_status_t fit_status;
    logic [AW-1:0]         fit_pick;
    logic [SIZE_BITS-1:0]  fit_best;

    // ------------------------------------------------------------------------
    // Configuration registers: written on the access phase, read back as is.
    // Only paddr[2] selects; the low address bits are ignored.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= fpfa_pkg::MODE_FIRST;
            block_count_reg <= 5'd0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                fpfa_pkg::REG_FIT_MODE:    fit_mode_reg    <= pwdata[1:0];
                fpfa_pkg::REG_BLOCK_COUNT: block_count_reg <= pwdata[4:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fpfa_pkg::REG_FIT_MODE:    prdata = {30'd0, fit_mode_reg};
            fpfa_pkg::REG_BLOCK_COUNT: prdata = {27'd0, block_count_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Item handshake. Take items only while idle; a finished result may still
    // sit in the output register meanwhile.
    // ------------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;

    // a load beyond the table depth is dropped
    assign load_ok = (LW'(entry_index) < MAX_LW);
    assign ram_we  = in_accept && (opcode == fpfa_pkg::OP_LOAD) && load_ok;

    // clip the search length to the table depth
    assign count_lw  = LW'(block_count_reg);
    assign done_scan = (scan_idx_reg >= limit_reg) || fit_status.stop;
    assign ram_re    = (state_reg == ST_SCAN) && !done_scan;

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_PARTITIONS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(entry_index)),
        .wdata (SIZE_BITS'(size_value)),
        .re    (ram_re),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // The compare unit sees each entry in the cycle after its read was issued.
    assign fit_ctrl.init     = in_accept && (opcode == fpfa_pkg::OP_ALLOC);
    assign fit_ctrl.step     = (state_reg == ST_SCAN) && pend_reg;
    assign fit_ctrl.keep_min = (fit_mode_reg == fpfa_pkg::MODE_BEST);
    assign fit_ctrl.keep_max = (fit_mode_reg == fpfa_pkg::MODE_WORST);

    fpfa_fit_unit #(
        .AW        (AW),
        .SIZE_BITS (SIZE_BITS)
    ) u_fit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (fit_ctrl),
        .entry_index (cmp_idx_reg),
        .entry_size  (ram_rdata),
        .entry_used  (used_reg[cmp_idx_reg]),
        .req_size    (req_size_reg),
        .status      (fit_status),
        .pick        (fit_pick),
        .best        (fit_best)
    );

    assign diff = fit_best - req_size_reg;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        scan_idx_next      = scan_idx_reg;
        limit_next         = limit_reg;
        pend_next          = 1'b0;
        cmp_idx_next       = cmp_idx_reg;
        req_size_next      = req_size_reg;
        used_next          = used_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        granted_next       = granted_reg;
        chosen_index_next  = chosen_index_reg;
        chosen_size_next   = chosen_size_reg;
        fragmentation_next = fragmentation_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (opcode)
                        fpfa_pkg::OP_CLEAR:
                        begin
                            used_next = '0;
                        end
                        fpfa_pkg::OP_ALLOC:
                        begin
                            req_size_next = SIZE_BITS'(size_value);
                            scan_idx_next = '0;
                            limit_next    = (count_lw > MAX_LW) ? MAX_LW : count_lw;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            // loads go straight to the RAM; opcode three is dropped
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle, let the last one drain, then finish
                if (!done_scan)
                begin
                    pend_next     = 1'b1;
                    cmp_idx_next  = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + LW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (finish_go)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = fit_status.found;
                    if (fit_status.found)
                    begin
                        used_next[fit_pick] = 1'b1;
                        chosen_index_next   = 4'(fit_pick);
                        chosen_size_next    = 16'(fit_best);
                        fragmentation_next  = 16'(diff);
                    end
                    else
                    begin
                        chosen_index_next  = 4'd0;
                        chosen_size_next   = 16'd0;
                        fragmentation_next = 16'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            limit_reg     <= '0;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            limit_reg     <= limit_next;
            pend_reg      <= pend_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg       <= cmp_idx_next;
        req_size_reg      <= req_size_next;
        granted_reg       <= granted_next;
        chosen_index_reg  <= chosen_index_next;
        chosen_size_reg   <= chosen_size_next;
        fragmentation_reg <= fragmentation_next;
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign chosen_index  = chosen_index_reg;
    assign chosen_size   = chosen_size_reg;
    assign fragmentation = fragmentation_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `FPFA_ASSERT(a_scan_bounded, scan_idx_reg <= limit_reg)
    `FPFA_ASSERT(a_miss_index, (out_valid && !granted) |-> (chosen_index == 4'd0))
    `FPFA_ASSERT(a_miss_size, (out_valid && !granted) |-> (chosen_size == 16'd0))
    `FPFA_ASSERT(a_miss_frag, (out_valid && !granted) |-> (fragmentation == 16'd0))
    `FPFA_ASSERT(a_frag_le_size, (out_valid && granted) |-> (fragmentation <= chosen_size))
    `FPFA_ASSERT_NEXT(a_grant_used, finish_go && fit_status.found, used_reg[$past(fit_pick)])

endmodule
